// File: src/rgar_pkg.sv
// Shared types and constants for the read gene assignment resolver.
package rgar_pkg;

  localparam int GENE_W       = 15;
  localparam int SCORE_W      = 16;
  localparam int MISMATCH_W   = 11;
  localparam int CARRIED_SLOTS = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // which running-best track a candidate feeds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_PROBE   = 2'd1;
  localparam logic [1:0] KIND_GENOMIC = 2'd2;

  typedef logic [GENE_W-1:0] gene_t;

  // classified candidate, as held in the queue
  typedef struct packed {
    logic [1:0]                kind;
    logic signed [SCORE_W-1:0] score;
    gene_t                     gene;
    logic                      multi;
    logic                      last;
  } entry_t;

endpackage

// File: src/rgar_front.sv
// Front end: scores one candidate and reduces its gene list.
module rgar_front #(
  parameter int SLOTS = 4
) (
  input  logic                         candidate_valid,
  input  logic                         is_genomic,
  input  logic                         probe_check_ok,
  input  logic signed [15:0]           align_score,
  input  logic signed [10:0]           mismatch_count,
  input  logic [14:0]                  primary_gene,
  input  logic [14:0]                  extra_gene_0,
  input  logic [14:0]                  extra_gene_1,
  input  logic [14:0]                  extra_gene_2,
  input  logic [14:0]                  extra_gene_3,
  input  logic                         last_of_read,
  output rgar_pkg::entry_t             entry,
  output logic                         keep
);
  import rgar_pkg::*;

  localparam int USED = (SLOTS < CARRIED_SLOTS) ? SLOTS : CARRIED_SLOTS;

  gene_t                     genes [0:CARRIED_SLOTS];
  gene_t                     first;
  logic                      multi;
  logic signed [SCORE_W-1:0] nm_ext;
  logic signed [SCORE_W-1:0] score;
  logic [1:0]                kind;

  always_comb begin
    genes[0] = (USED > 0) ? extra_gene_0 : '0;
    genes[1] = (USED > 1) ? extra_gene_1 : '0;
    genes[2] = (USED > 2) ? extra_gene_2 : '0;
    genes[3] = (USED > 3) ? extra_gene_3 : '0;
    // primary gene counts for probe alignments only, after the extras
    genes[CARRIED_SLOTS] = is_genomic ? '0 : primary_gene;
  end

  always_comb begin
    first = '0;
    for (int i = 0; i <= CARRIED_SLOTS; i++) begin
      if (first == '0) begin
        first = genes[i];
      end
    end
    multi = 1'b0;
    for (int i = 0; i <= CARRIED_SLOTS; i++) begin
      if (genes[i] != '0 && genes[i] != first) begin
        multi = 1'b1;
      end
    end
  end

  always_comb begin
    nm_ext = {{(SCORE_W-MISMATCH_W){mismatch_count[MISMATCH_W-1]}}, mismatch_count};
    if (align_score != '0) begin
      score = align_score;
    end else if (!mismatch_count[MISMATCH_W-1]) begin
      score = SCORE_W'(16'sd0 - nm_ext);
    end else begin
      score = '0;
    end
  end

  always_comb begin
    kind = KIND_NONE;
    if (candidate_valid && first != '0) begin
      if (is_genomic) begin
        kind = KIND_GENOMIC;
      end else if (probe_check_ok) begin
        kind = KIND_PROBE;
      end
    end
  end

  assign entry.kind  = kind;
  assign entry.score = score;
  assign entry.gene  = first;
  assign entry.multi = multi;
  assign entry.last  = last_of_read;
  // items with no effect on any track and no end mark are dropped here
  assign keep = last_of_read || (kind != KIND_NONE);

endmodule

// File: src/rgar_queue.sv
// Small queue between the front end and the resolving back end.
module rgar_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rgar_pkg::entry_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output rgar_pkg::entry_t head
);
  import rgar_pkg::*;

  entry_t             slots [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

endmodule

// File: src/rgar_back.sv
// Back end: running-best tracks per read and the output register.
module rgar_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  rgar_pkg::entry_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [14:0]      resolved_gene
);
  import rgar_pkg::*;

  logic                      probe_seen, probe_seen_next;
  logic signed [SCORE_W-1:0] probe_best_score, probe_best_score_next;
  gene_t                     probe_gene, probe_gene_next;
  logic                      probe_ambiguous, probe_ambiguous_next;
  logic                      genomic_seen, genomic_seen_next;
  logic signed [SCORE_W-1:0] genomic_best_score, genomic_best_score_next;
  gene_t                     genomic_gene, genomic_gene_next;
  logic                      genomic_conflict, genomic_conflict_next;
  gene_t                     result;

  // a read end needs the output register free or draining
  assign pop = head_valid && (!head.last || !out_valid || !out_stall);

  always_comb begin
    probe_seen_next         = probe_seen;
    probe_best_score_next   = probe_best_score;
    probe_gene_next         = probe_gene;
    probe_ambiguous_next    = probe_ambiguous;
    genomic_seen_next       = genomic_seen;
    genomic_best_score_next = genomic_best_score;
    genomic_gene_next       = genomic_gene;
    genomic_conflict_next   = genomic_conflict;
    case (head.kind)
      KIND_PROBE: begin
        if (!probe_seen || head.score > probe_best_score) begin
          probe_seen_next       = 1'b1;
          probe_best_score_next = head.score;
          probe_gene_next       = head.gene;
          probe_ambiguous_next  = head.multi;
        end else if (head.score == probe_best_score) begin
          if (head.multi || head.gene != probe_gene) begin
            probe_ambiguous_next = 1'b1;
          end
        end
      end
      KIND_GENOMIC: begin
        if (!genomic_seen || head.score > genomic_best_score) begin
          genomic_seen_next       = 1'b1;
          genomic_best_score_next = head.score;
          genomic_gene_next       = head.gene;
          genomic_conflict_next   = head.multi;
        end else if (head.score == genomic_best_score) begin
          if (head.multi || head.gene != genomic_gene) begin
            genomic_conflict_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // probe track wins whenever it has anything
  always_comb begin
    result = '0;
    if (probe_seen_next) begin
      result = probe_ambiguous_next ? '0 : probe_gene_next;
    end else if (genomic_seen_next) begin
      result = genomic_conflict_next ? '0 : genomic_gene_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_seen         <= 1'b0;
      probe_best_score   <= '0;
      probe_gene         <= '0;
      probe_ambiguous    <= 1'b0;
      genomic_seen       <= 1'b0;
      genomic_best_score <= '0;
      genomic_gene       <= '0;
      genomic_conflict   <= 1'b0;
    end else if (pop) begin
      if (head.last) begin
        probe_seen         <= 1'b0;
        probe_best_score   <= '0;
        probe_gene         <= '0;
        probe_ambiguous    <= 1'b0;
        genomic_seen       <= 1'b0;
        genomic_best_score <= '0;
        genomic_gene       <= '0;
        genomic_conflict   <= 1'b0;
      end else begin
        probe_seen         <= probe_seen_next;
        probe_best_score   <= probe_best_score_next;
        probe_gene         <= probe_gene_next;
        probe_ambiguous    <= probe_ambiguous_next;
        genomic_seen       <= genomic_seen_next;
        genomic_best_score <= genomic_best_score_next;
        genomic_gene       <= genomic_gene_next;
        genomic_conflict   <= genomic_conflict_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      resolved_gene <= result;
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (pop && head.last) |=> out_valid)
    else $error("read end popped without a result");

  a_clear_after_read: assert property (@(posedge clk) disable iff (rst)
    (pop && head.last) |=> (!probe_seen && !genomic_seen && !probe_ambiguous
                            && !genomic_conflict))
    else $error("track state not cleared after read end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(pop && head.last))
    else $error("pending result overwritten");

  a_flags_need_seen: assert property (@(posedge clk) disable iff (rst)
    (!probe_ambiguous || probe_seen) && (!genomic_conflict || genomic_seen))
    else $error("ambiguity flag set on an empty track");

endmodule

// File: src/read_gene_assignment_resolver_top.sv
// Top level of the read gene assignment resolver.
//
// Takes the alignment candidates of one read, one request per cycle unless
// stalled, and returns one resolved gene index on the request marked
// last_of_read (0 means the read is dropped or has no gene). A candidate
// scores with its alignment score, or minus its mismatch count when the
// score is zero and the count is known, else zero. Probe candidates that
// pass the shape check and carry a gene feed the probe track; the top probe
// score must reduce to one distinct gene. Genomic candidates with an extra
// gene feed the genomic track, used only when no probe candidate qualified;
// every top genomic candidate must carry one distinct extra gene and all
// must agree. Rate: one request per cycle sustained while in_stall is low.
// The front end scores and classifies a request in the cycle it is
// accepted and writes it into a four-entry queue; the back end pops one
// entry per cycle into the running-best registers unless a read end waits
// on a stalled output register. Requests with no end mark that feed no
// track are dropped at the front end. in_stall rises only when the queue is
// full, which happens only while out_stall holds back a read end.
module read_gene_assignment_resolver_top #(
  parameter int EXTRA_GENE_SLOTS = 4   // extra slots examined, up to 4; larger values act as 4
) (
  input  logic               clk,
  input  logic               rst,
  // candidate channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               candidate_valid,
  input  logic               is_genomic,
  input  logic               probe_check_ok,
  input  logic signed [15:0] align_score,
  input  logic signed [10:0] mismatch_count,
  input  logic [14:0]        primary_gene,
  input  logic [14:0]        extra_gene_0,
  input  logic [14:0]        extra_gene_1,
  input  logic [14:0]        extra_gene_2,
  input  logic [14:0]        extra_gene_3,
  input  logic               last_of_read,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [14:0]        resolved_gene
);
  import rgar_pkg::*;

  entry_t front_entry;
  logic   front_keep;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_head_valid;
  entry_t q_head;

  // classify the incoming candidate
  rgar_front #(
    .SLOTS (EXTRA_GENE_SLOTS)
  ) u_front (
    .candidate_valid (candidate_valid),
    .is_genomic      (is_genomic),
    .probe_check_ok  (probe_check_ok),
    .align_score     (align_score),
    .mismatch_count  (mismatch_count),
    .primary_gene    (primary_gene),
    .extra_gene_0    (extra_gene_0),
    .extra_gene_1    (extra_gene_1),
    .extra_gene_2    (extra_gene_2),
    .extra_gene_3    (extra_gene_3),
    .last_of_read    (last_of_read),
    .entry           (front_entry),
    .keep            (front_keep)
  );

  // stall depends only on registered queue occupancy
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && front_keep;

  rgar_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (front_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // running bests and result register
  rgar_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_head_valid),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .resolved_gene (resolved_gene)
  );

endmodule

// File: test/read_gene_assignment_resolver_top_tb.sv
// Self-checking testbench for the read gene assignment resolver top level.
module read_gene_assignment_resolver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgar_pkg::*;

  localparam int EXTRA_SLOTS    = 4;
  localparam int SLOTS_SEEN     = (EXTRA_SLOTS < CARRIED_SLOTS) ? EXTRA_SLOTS : CARRIED_SLOTS;
  localparam int HOLD_CYCLES    = 120;   // long receiver hold-off, fills the queue
  localparam int WATCHDOG_LIMIT = 1500;  // cycles with no handshake on either side
  localparam int REPORT_LIMIT   = 10;

  // fixed genes for the directed reads
  localparam gene_t GA   = 15'h1111;
  localparam gene_t GB   = 15'h2AAA;
  localparam gene_t GC   = 15'h5555;
  localparam gene_t GD   = 15'h0F0F;
  localparam gene_t GE   = 15'h7000;
  localparam gene_t GMAX = 15'h7FFF;

  // one candidate request as seen on the input ports
  typedef struct packed {
    logic                         cand;
    logic                         genomic;
    logic                         check_ok;
    logic signed [SCORE_W-1:0]    align;
    logic signed [MISMATCH_W-1:0] mism;
    gene_t                        primary;
    gene_t [CARRIED_SLOTS-1:0]    extra;
    logic                         last;
  } candidate_t;

  logic                         clk;
  logic                         rst             = 1'b1;
  logic                         in_valid        = 1'b0;
  logic                         in_stall;
  logic                         candidate_valid = 1'b0;
  logic                         is_genomic      = 1'b0;
  logic                         probe_check_ok  = 1'b0;
  logic signed [SCORE_W-1:0]    align_score     = '0;
  logic signed [MISMATCH_W-1:0] mismatch_count  = '0;
  logic [GENE_W-1:0]            primary_gene    = '0;
  logic [GENE_W-1:0]            extra_gene_0    = '0;
  logic [GENE_W-1:0]            extra_gene_1    = '0;
  logic [GENE_W-1:0]            extra_gene_2    = '0;
  logic [GENE_W-1:0]            extra_gene_3    = '0;
  logic                         last_of_read    = 1'b0;
  logic                         out_valid;
  logic                         out_stall       = 1'b0;
  logic [GENE_W-1:0]            resolved_gene;

  // idling controls, written by the test tasks
  bit tx_idling    = 1'b1;
  bit rx_idling    = 1'b1;
  bit hold_request = 1'b0;

  gene_t expected_genes[$];  // resolved genes still owed by the block
  int    items_sent  = 0;
  int    mismatches  = 0;
  int    quiet_cycles = 0;
  int    rx_left     = 0;
  gene_t want;

  // running-best state of the predictor
  bit                        pr_found;
  logic signed [SCORE_W-1:0] pr_top;
  gene_t                     pr_gene;
  bit                        pr_tied;
  bit                        gn_found;
  logic signed [SCORE_W-1:0] gn_top;
  gene_t                     gn_gene;
  bit                        gn_clash;

  read_gene_assignment_resolver_top #(
    .EXTRA_GENE_SLOTS(EXTRA_SLOTS)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .candidate_valid(candidate_valid),
    .is_genomic     (is_genomic),
    .probe_check_ok (probe_check_ok),
    .align_score    (align_score),
    .mismatch_count (mismatch_count),
    .primary_gene   (primary_gene),
    .extra_gene_0   (extra_gene_0),
    .extra_gene_1   (extra_gene_1),
    .extra_gene_2   (extra_gene_2),
    .extra_gene_3   (extra_gene_3),
    .last_of_read   (last_of_read),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .resolved_gene  (resolved_gene)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // first distinct nonzero gene, plus a flag once a second one shows up
  function automatic void note_gene(input gene_t g, inout gene_t first, inout bit multi);
    if (g != '0) begin
      if (first == '0) first = g;
      else if (g != first) multi = 1'b1;
    end
  endfunction

  function automatic void clear_tracks();
    pr_found = 1'b0;
    pr_top   = '0;
    pr_gene  = '0;
    pr_tied  = 1'b0;
    gn_found = 1'b0;
    gn_top   = '0;
    gn_gene  = '0;
    gn_clash = 1'b0;
  endfunction

  // fold one accepted request into the tracks; at read end give the gene
  function automatic void resolve_candidate(input candidate_t c, output bit done,
                                            output gene_t gene_out);
    logic signed [SCORE_W-1:0] score;
    gene_t first;
    bit    multi;
    done     = 1'b0;
    gene_out = '0;
    first    = '0;
    multi    = 1'b0;
    if (c.cand) begin
      // alignment score wins, else minus a known edit distance, else zero
      if ($signed(c.align) != 0) begin
        score = c.align;
      end else if ($signed(c.mism) >= 0) begin
        score = $signed(c.mism);
        score = -score;
      end else begin
        score = '0;
      end
      for (int i = 0; i < SLOTS_SEEN; i++) note_gene(c.extra[i], first, multi);
      if (!c.genomic) begin
        note_gene(c.primary, first, multi);
        if (c.check_ok && first != '0) begin
          if (!pr_found || score > pr_top) begin
            pr_found = 1'b1;
            pr_top   = score;
            pr_gene  = first;
            pr_tied  = multi;
          end else if (score == pr_top && (multi || first != pr_gene)) begin
            pr_tied = 1'b1;
          end
        end
      end else if (first != '0) begin
        // genomic track: primary gene plays no part
        if (!gn_found || score > gn_top) begin
          gn_found = 1'b1;
          gn_top   = score;
          gn_gene  = first;
          gn_clash = multi;
        end else if (score == gn_top && (multi || first != gn_gene)) begin
          gn_clash = 1'b1;
        end
      end
    end
    if (c.last) begin
      done = 1'b1;
      if (pr_found) gene_out = pr_tied ? gene_t'(0) : pr_gene;
      else if (gn_found) gene_out = gn_clash ? gene_t'(0) : gn_gene;
      clear_tracks();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Request building
  // ---------------------------------------------------------------------

  function automatic candidate_t mk(input bit genomic, input bit ok, input int align,
                                    input int mism, input gene_t primary, input gene_t e0,
                                    input gene_t e1, input gene_t e2, input gene_t e3,
                                    input bit last);
    candidate_t c;
    c.cand     = 1'b1;
    c.genomic  = genomic;
    c.check_ok = ok;
    c.align    = SCORE_W'(align);
    c.mism     = MISMATCH_W'(mism);
    c.primary  = primary;
    c.extra    = {e3, e2, e1, e0};
    c.last     = last;
    return c;
  endfunction

  // mostly genes from a small per-read pool so ties and clashes happen often
  function automatic gene_t pick_gene(input gene_t [2:0] pool);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      9:          return gene_t'($urandom_range(0, 32767));
      default:    return pool[$urandom_range(0, 2)];
    endcase
  endfunction

  function automatic candidate_t random_candidate(input gene_t [2:0] pool);
    candidate_t c;
    int s;
    c.cand     = 1'b1;
    c.genomic  = 1'($urandom_range(0, 1));
    c.check_ok = ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        s = $urandom_range(0, 4);
        c.align = SCORE_W'(s - 2);  // small values collide often
      end
      6, 7:    c.align = SCORE_W'($urandom_range(0, 65535));
      default: c.align = '0;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: c.mism = MISMATCH_W'($urandom_range(0, 3));
      5, 6:          c.mism = '1;
      7:             c.mism = MISMATCH_W'($urandom_range(0, 2047));
      8:             c.mism = MISMATCH_W'($urandom_range(1024, 2047));
      default:       c.mism = MISMATCH_W'($urandom_range(0, 1023));
    endcase
    c.primary  = pick_gene(pool);
    c.extra[0] = pick_gene(pool);
    for (int i = 1; i < CARRIED_SLOTS; i++)
      c.extra[i] = ($urandom_range(0, 3) == 0) ? pick_gene(pool) : gene_t'(0);
    c.last = 1'b0;
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver: optional gap, then hold the payload until accepted
  // ---------------------------------------------------------------------
  task automatic send_candidate(input candidate_t c);
    int    gap;
    bit    done;
    gene_t g;
    if (tx_idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    candidate_valid <= c.cand;
    is_genomic      <= c.genomic;
    probe_check_ok  <= c.check_ok;
    align_score     <= c.align;
    mismatch_count  <= c.mism;
    primary_gene    <= c.primary;
    extra_gene_0    <= c.extra[0];
    extra_gene_1    <= c.extra[1];
    extra_gene_2    <= c.extra[2];
    extra_gene_3    <= c.extra[3];
    last_of_read    <= c.last;
    // values read right after the edge are the ones the block saw at it
    @(posedge clk);
    while (in_stall) @(posedge clk);
    resolve_candidate(c, done, g);
    if (done) expected_genes = {expected_genes, g};
    items_sent++;
  endtask

  // one read of random length; sometimes interleaved with ignored requests,
  // sometimes closed by an empty end request, sometimes empty altogether
  task automatic send_random_read();
    gene_t [2:0] pool;
    candidate_t  c;
    int          len;
    bit          close_empty;
    for (int k = 0; k < 3; k++) pool[k] = gene_t'($urandom_range(1, 32767));
    len         = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
    close_empty = ($urandom_range(0, 11) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        c = random_candidate(pool);
        c.cand = 1'b0;
        send_candidate(c);
      end
      c = random_candidate(pool);
      c.last = (i == len - 1) && !close_empty;
      send_candidate(c);
    end
    if (len == 0 || close_empty) begin
      c = random_candidate(pool);
      c.cand = 1'b0;
      c.last = 1'b1;
      send_candidate(c);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_genes.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_directed_cases();
    candidate_t c;
    c = '0;
    c.last = 1'b1;
    send_candidate(c);                                       // empty read
    c = '1;
    c.cand = 1'b0;
    c.last = 1'b0;
    send_candidate(c);                                       // ignored request
    send_candidate(mk(0, 1,  32767,     0, GMAX, 0,  0,  0,  0,    1));
    send_candidate(mk(0, 1, -32768,     0, 0,    0,  0,  0,  GMAX, 1));
    // zero score from an exact match ties with unknown distance
    send_candidate(mk(0, 1,      0,     0, GA,   0,  0,  0,  0,    0));
    send_candidate(mk(0, 1,      0,    -1, 0,    GA, 0,  0,  0,    1));
    // largest distance loses to any negative (unknown) count
    send_candidate(mk(0, 1,      0,  1023, GA,   0,  0,  0,  0,    0));
    send_candidate(mk(0, 1,      0, -1024, 0,    0,  GB, 0,  0,    1));
    // tie between different probe genes drops the read
    send_candidate(mk(0, 1,      5,     3, GA,   0,  0,  0,  0,    0));
    send_candidate(mk(0, 1,      5,     3, GB,   0,  0,  0,  0,    1));
    // a higher score clears an earlier ambiguity
    send_candidate(mk(0, 1,      5,     0, GA,   GB, 0,  0,  0,    0));
    send_candidate(mk(0, 1,      9,     0, 0,    0,  0,  GC, 0,    1));
    // failed probe check falls through to genomic
    send_candidate(mk(0, 0,    100,     0, GA,   0,  0,  0,  0,    0));
    send_candidate(mk(1, 1,      3,     0, 0,    0,  GD, 0,  0,    1));
    // probe without gene; genomic repeats one gene, primary ignored
    send_candidate(mk(0, 1,     50,     0, 0,    0,  0,  0,  0,    0));
    send_candidate(mk(1, 0,      4,     0, GE,   GD, 0,  GD, 0,    1));
    // genomic disagreement at the top score
    send_candidate(mk(1, 0,      4,     0, 0,    GD, 0,  0,  0,    0));
    send_candidate(mk(1, 0,      4,     0, 0,    0,  0,  0,  GE,   1));
    // genomic with primary only does not rank
    send_candidate(mk(1, 0,      7,     0, GE,   0,  0,  0,  0,    0));
    send_candidate(mk(1, 0,      2,     0, 0,    0,  0,  GD, 0,    1));
    // any probe hit beats a better genomic one; read closed by empty request
    send_candidate(mk(1, 1,    100,     0, 0,    GD, 0,  0,  0,    0));
    send_candidate(mk(0, 1,     -5,     0, GA,   0,  0,  0,  0,    0));
    c = '0;
    c.last = 1'b1;
    send_candidate(c);
    // two extra genes on one genomic candidate
    send_candidate(mk(1, 0,      1,     0, 0,    GD, GE, 0,  0,    1));
  endtask

  task automatic test_random_reads(input int target);
    while (items_sent < target) begin
      if ($urandom_range(0, 24) == 0) tx_idling <= ~tx_idling;
      if ($urandom_range(0, 24) == 0) rx_idling <= ~rx_idling;
      send_random_read();
    end
    tx_idling <= 1'b1;
    rx_idling <= 1'b1;
  endtask

  // receiver holds off while single-candidate reads keep coming
  task automatic test_output_hold();
    gene_t [2:0] pool;
    candidate_t  c;
    for (int k = 0; k < 3; k++) pool[k] = gene_t'($urandom_range(1, 32767));
    // nothing on offer while the hold is being set up
    in_valid <= 1'b0;
    @(posedge clk);
    tx_idling    <= 1'b0;
    rx_idling    <= 1'b0;
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    for (int k = 0; k < 24; k++) begin
      c = random_candidate(pool);
      c.last = 1'b1;
      send_candidate(c);
    end
    tx_idling <= 1'b1;
    rx_idling <= 1'b1;
  endtask

  task automatic test_pause_until_drained();
    repeat (6) send_random_read();
    wait_results_drained();
    repeat (6) send_random_read();
  endtask

  task automatic test_streaming(input int count);
    int target;
    target = items_sent + count;
    tx_idling <= 1'b0;
    rx_idling <= 1'b0;
    while (items_sent < target) send_random_read();
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, or one long hold when requested
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_left = 0;
    end else begin
      if (hold_request) rx_left = HOLD_CYCLES;
      else if (rx_left == 0 && rx_idling && $urandom_range(0, 7) == 0)
        rx_left = $urandom_range(1, 18);
      if (rx_left > 0) begin
        out_stall <= 1'b1;
        rx_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_genes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: unexpected result, expected none, actual resolved_gene %0d",
                   resolved_gene);
      end else begin
        want = expected_genes.pop_front();
        if (resolved_gene !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("ERROR: resolved_gene expected %0d, actual %0d", want, resolved_gene);
        end
      end
    end
  end

  // watchdog: no handshake on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_tracks();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_reads(1000);
    test_output_hold();
    test_pause_until_drained();
    test_streaming(200);
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_genes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
src/rgar_pkg.sv
src/rgar_front.sv
src/rgar_queue.sv
src/rgar_back.sv
src/read_gene_assignment_resolver_top.sv
test/read_gene_assignment_resolver_top_tb.sv
